// File: rtl/core/segi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection package
// Relation codes shared by the front end, the back end and the checker.
// ----------------------------------------------------------------------------
package segi_pkg;

   typedef logic [1:0] rel_type;

   localparam rel_type REL_DISJOINT = 2'd0;
   localparam rel_type REL_SINGLE   = 2'd1;
   localparam rel_type REL_OVERLAP  = 2'd2;

endpackage

// File: rtl/core/segi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined signed divider
// Restoring division, one quotient bit per stage, truncating toward zero.
// The quotient must fit in QW bits; a side tag travels with each word.
// ----------------------------------------------------------------------------
module segi_div #(
   parameter int NW = 51,
   parameter int DW = 35,
   parameter int QW = 16,
   parameter int TW = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [NW-1:0] num,
   input  logic signed [DW-1:0] den,
   input  logic        [TW-1:0] in_tag,
   output logic                 out_valid,
   output logic signed [QW-1:0] quo,
   output logic        [TW-1:0] out_tag
);

   localparam int RW = (NW > DW + QW) ? NW : DW + QW;

   logic          v_ff   [0:QW];
   logic          v_in   [0:QW];
   logic [RW-1:0] rem_ff [0:QW];
   logic [RW-1:0] rem_in [0:QW];
   logic [DW-1:0] dv_ff  [0:QW];
   logic [DW-1:0] dv_in  [0:QW];
   logic [QW-1:0] q_ff   [0:QW];
   logic [QW-1:0] q_in   [0:QW];
   logic          neg_ff [0:QW];
   logic          neg_in [0:QW];
   logic [TW-1:0] tag_ff [0:QW];
   logic [TW-1:0] tag_in [0:QW];

   logic [NW-1:0] mag_n;
   logic [DW-1:0] mag_d;

   assign mag_n = num[NW-1] ? (~num + 1'b1) : num;
   assign mag_d = den[DW-1] ? (~den + 1'b1) : den;

   always_comb begin
      logic [RW-1:0] trial;
      logic          take;
      v_in[0]   = in_valid;
      rem_in[0] = RW'(mag_n);
      dv_in[0]  = mag_d;
      q_in[0]   = '0;
      neg_in[0] = num[NW-1] ^ den[DW-1];
      tag_in[0] = in_tag;
      for (int k = 0; k < QW; k++) begin
         trial       = RW'(dv_ff[k]) << (QW - 1 - k);
         take        = rem_ff[k] >= trial;
         v_in[k+1]   = v_ff[k];
         rem_in[k+1] = take ? (rem_ff[k] - trial) : rem_ff[k];
         dv_in[k+1]  = dv_ff[k];
         q_in[k+1]   = {q_ff[k][QW-2:0], take};
         neg_in[k+1] = neg_ff[k];
         tag_in[k+1] = tag_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= QW; s++) v_ff[s] <= 1'b0;
      end else if (en) begin
         for (int s = 0; s <= QW; s++) v_ff[s] <= v_in[s];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s <= QW; s++) begin
            rem_ff[s] <= rem_in[s];
            dv_ff[s]  <= dv_in[s];
            q_ff[s]   <= q_in[s];
            neg_ff[s] <= neg_in[s];
            tag_ff[s] <= tag_in[s];
         end
      end
   end

   assign out_valid = v_ff[QW];
   assign quo       = neg_ff[QW] ? (~q_ff[QW] + 1'b1) : q_ff[QW];
   assign out_tag   = tag_ff[QW];

endmodule

// File: rtl/core/segi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection front end
// Takes a segment pair, forms the orientation tests and line coefficients,
// and classifies the pair. Two register stages under one stall.
// ----------------------------------------------------------------------------
module segi_front #(
   parameter int W = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [8*W-1:0]          in_coords,
   output logic                    out_valid,
   input  logic                    out_ready,
   output segi_pkg::rel_type       rel,
   output logic signed [W-1:0]     ax,
   output logic signed [W-1:0]     ay,
   output logic signed [W-1:0]     cx,
   output logic signed [W-1:0]     cy,
   output logic signed [W:0]       a1,
   output logic signed [W:0]       b1,
   output logic signed [W:0]       a2,
   output logic signed [W:0]       b2,
   output logic signed [2*W:0]     c1,
   output logic signed [2*W:0]     c2,
   output logic signed [2*W+2:0]   den
);

   import segi_pkg::*;

   localparam int W1  = W + 1;
   localparam int PW  = 2 * W + 2;
   localparam int CPW = 2 * W;
   localparam int CW  = 2 * W + 1;
   localparam int OW  = 2 * W + 3;

   function automatic logic signed [W-1:0] smax(input logic signed [W-1:0] p,
                                                input logic signed [W-1:0] q);
      smax = (p > q) ? p : q;
   endfunction

   function automatic logic signed [W-1:0] smin(input logic signed [W-1:0] p,
                                                input logic signed [W-1:0] q);
      smin = (p < q) ? p : q;
   endfunction

   logic adv;

   // Stage 1: captured coordinates.
   logic           f1_valid_ff, f1_valid_in;
   logic [8*W-1:0] f1_data_ff;

   logic signed [W-1:0] s1_ax, s1_ay, s1_bx, s1_by, s1_cx, s1_cy, s1_dx, s1_dy;
   logic signed [W1-1:0] e_dc_x, e_dc_y, e_ac_x, e_ac_y, e_bc_x, e_bc_y;
   logic signed [W1-1:0] e_ba_x, e_ba_y, e_ca_x, e_ca_y, e_da_x, e_da_y;
   logic signed [W1-1:0] a1_in, a2_in;

   // Stage 2: products.
   logic           f2_valid_ff, f2_valid_in;
   logic [8*W-1:0] f2_data_ff;
   logic signed [PW-1:0]  o1p_ff, o1q_ff, o2p_ff, o2q_ff, o3p_ff, o3q_ff, o4p_ff, o4q_ff;
   logic signed [PW-1:0]  o1p_in, o1q_in, o2p_in, o2q_in, o3p_in, o3q_in, o4p_in, o4q_in;
   logic signed [CPW-1:0] c1p_ff, c1q_ff, c2p_ff, c2q_ff;
   logic signed [CPW-1:0] c1p_in, c1q_in, c2p_in, c2q_in;
   logic signed [PW-1:0]  dnp_ff, dnq_ff, dnp_in, dnq_in;
   logic signed [W1-1:0]  a1_ff, b1_ff, a2_ff, b2_ff;

   logic signed [W-1:0] s2_ax, s2_ay, s2_bx, s2_by, s2_cx, s2_cy, s2_dx, s2_dy;
   logic signed [OW-1:0] o1, o2, o3, o4;
   logic pos1, pos2, pos3, pos4, neg1, neg2, neg3, neg4;
   logic collinear, box_x, box_y, straddle_ab, straddle_cd;

   assign adv      = !f2_valid_ff || out_ready;
   assign in_ready = adv;

   assign f1_valid_in = adv ? in_valid : f1_valid_ff;
   assign f2_valid_in = adv ? f1_valid_ff : f2_valid_ff;

   assign {s1_dy, s1_dx, s1_cy, s1_cx, s1_by, s1_bx, s1_ay, s1_ax} = f1_data_ff;

   assign e_dc_x = W1'(s1_dx) - W1'(s1_cx);
   assign e_dc_y = W1'(s1_dy) - W1'(s1_cy);
   assign e_ac_x = W1'(s1_ax) - W1'(s1_cx);
   assign e_ac_y = W1'(s1_ay) - W1'(s1_cy);
   assign e_bc_x = W1'(s1_bx) - W1'(s1_cx);
   assign e_bc_y = W1'(s1_by) - W1'(s1_cy);
   assign e_ba_x = W1'(s1_bx) - W1'(s1_ax);
   assign e_ba_y = W1'(s1_by) - W1'(s1_ay);
   assign e_ca_x = W1'(s1_cx) - W1'(s1_ax);
   assign e_ca_y = W1'(s1_cy) - W1'(s1_ay);
   assign e_da_x = W1'(s1_dx) - W1'(s1_ax);
   assign e_da_y = W1'(s1_dy) - W1'(s1_ay);
   assign a1_in  = W1'(s1_ay) - W1'(s1_by);
   assign a2_in  = W1'(s1_cy) - W1'(s1_dy);

   assign o1p_in = e_dc_x * e_ac_y;
   assign o1q_in = e_dc_y * e_ac_x;
   assign o2p_in = e_dc_x * e_bc_y;
   assign o2q_in = e_dc_y * e_bc_x;
   assign o3p_in = e_ba_x * e_ca_y;
   assign o3q_in = e_ba_y * e_ca_x;
   assign o4p_in = e_ba_x * e_da_y;
   assign o4q_in = e_ba_y * e_da_x;
   assign c1p_in = s1_ax * s1_by;
   assign c1q_in = s1_ay * s1_bx;
   assign c2p_in = s1_cx * s1_dy;
   assign c2q_in = s1_cy * s1_dx;
   assign dnp_in = a2_in * e_ba_x;
   assign dnq_in = a1_in * e_dc_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
         f2_valid_ff <= f2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_data_ff <= in_coords;
         f2_data_ff <= f1_data_ff;
         o1p_ff <= o1p_in;
         o1q_ff <= o1q_in;
         o2p_ff <= o2p_in;
         o2q_ff <= o2q_in;
         o3p_ff <= o3p_in;
         o3q_ff <= o3q_in;
         o4p_ff <= o4p_in;
         o4q_ff <= o4q_in;
         c1p_ff <= c1p_in;
         c1q_ff <= c1q_in;
         c2p_ff <= c2p_in;
         c2q_ff <= c2q_in;
         dnp_ff <= dnp_in;
         dnq_ff <= dnq_in;
         a1_ff  <= a1_in;
         b1_ff  <= e_ba_x;
         a2_ff  <= a2_in;
         b2_ff  <= e_dc_x;
      end
   end

   assign {s2_dy, s2_dx, s2_cy, s2_cx, s2_by, s2_bx, s2_ay, s2_ax} = f2_data_ff;

   assign o1 = OW'(o1p_ff) - OW'(o1q_ff);
   assign o2 = OW'(o2p_ff) - OW'(o2q_ff);
   assign o3 = OW'(o3p_ff) - OW'(o3q_ff);
   assign o4 = OW'(o4p_ff) - OW'(o4q_ff);

   assign neg1 = o1[OW-1];
   assign neg2 = o2[OW-1];
   assign neg3 = o3[OW-1];
   assign neg4 = o4[OW-1];
   assign pos1 = !neg1 && (o1 != '0);
   assign pos2 = !neg2 && (o2 != '0);
   assign pos3 = !neg3 && (o3 != '0);
   assign pos4 = !neg4 && (o4 != '0);

   assign collinear = (o1 == '0) && (o2 == '0) && (o3 == '0) && (o4 == '0);

   assign box_x = (smax(s2_ax, s2_bx) >= smin(s2_cx, s2_dx)) &&
                  (smax(s2_cx, s2_dx) >= smin(s2_ax, s2_bx));
   assign box_y = (smax(s2_ay, s2_by) >= smin(s2_cy, s2_dy)) &&
                  (smax(s2_cy, s2_dy) >= smin(s2_ay, s2_by));

   // A and B must not lie strictly on the same side of CD, and vice versa.
   assign straddle_ab = !((pos1 && pos2) || (neg1 && neg2));
   assign straddle_cd = !((pos3 && pos4) || (neg3 && neg4));

   always_comb begin
      if (collinear) begin
         rel = (box_x && box_y) ? REL_OVERLAP : REL_DISJOINT;
      end else begin
         rel = (straddle_ab && straddle_cd) ? REL_SINGLE : REL_DISJOINT;
      end
   end

   assign out_valid = f2_valid_ff;
   assign ax  = s2_ax;
   assign ay  = s2_ay;
   assign cx  = s2_cx;
   assign cy  = s2_cy;
   assign a1  = a1_ff;
   assign b1  = b1_ff;
   assign a2  = a2_ff;
   assign b2  = b2_ff;
   assign c1  = CW'(c1p_ff) - CW'(c1q_ff);
   assign c2  = CW'(c2p_ff) - CW'(c2q_ff);
   assign den = OW'(dnp_ff) - OW'(dnq_ff);

endmodule

// File: rtl/core/segi_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection decoupling queue
// Four-entry FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module segi_queue #(
   parameter int DW = 235
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [DW-1:0] push_data,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output logic [DW-1:0] head_data
);

   localparam int DEPTH = 4;
   localparam int AW    = 2;
   localparam logic [AW:0] CNT_FULL = (AW + 1)'(DEPTH);

   logic [DW-1:0] slot_ff [0:DEPTH-1];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && head_valid;

   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/segi_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection back end
// Forms the y numerator, divides for y, then forms and divides for x, and
// holds the result word in the output register. One stall for the whole pipe.
// ----------------------------------------------------------------------------
module segi_back #(
   parameter int W = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  segi_pkg::rel_type       rel,
   input  logic signed [W-1:0]     ax,
   input  logic signed [W-1:0]     ay,
   input  logic signed [W-1:0]     cx,
   input  logic signed [W-1:0]     cy,
   input  logic signed [W:0]       a1,
   input  logic signed [W:0]       b1,
   input  logic signed [W:0]       a2,
   input  logic signed [W:0]       b2,
   input  logic signed [2*W:0]     c1,
   input  logic signed [2*W:0]     c2,
   input  logic signed [2*W+2:0]   den,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic                    intersects,
   output segi_pkg::rel_type       relation,
   output logic signed [W-1:0]     meet_x,
   output logic signed [W-1:0]     meet_y
);

   import segi_pkg::*;

   localparam int W1 = W + 1;
   localparam int PW = 2 * W + 2;
   localparam int CW = 2 * W + 1;
   localparam int OW = 2 * W + 3;
   localparam int NW = 3 * W + 3;
   localparam int TY = 3 + 2 * W1 + 2 * W;
   localparam int TX = 3 + W;

   logic en;

   // B1: partial products of the y numerator; c is split at bit W.
   logic signed [W1-1:0] c1_hi, c1_lo, c2_hi, c2_lo;
   logic                 b1v_ff, b1v_in;
   logic signed [PW-1:0] p1h_ff, p1l_ff, p2h_ff, p2l_ff;
   logic signed [PW-1:0] p1h_in, p1l_in, p2h_in, p2l_in;
   logic signed [OW-1:0] b1den_ff;
   rel_type              b1rel_ff;
   logic signed [W1-1:0] b1a1_ff, b1b1_ff, b1a2_ff, b1b2_ff;
   logic signed [W-1:0]  b1ax_ff, b1ay_ff, b1cx_ff, b1cy_ff;

   // B2: y numerator and branch selection for x.
   logic                 b2v_ff, b2v_in;
   logic signed [OW-1:0] num_hi, num_lo;
   logic signed [NW-1:0] num_ff, num_in;
   logic signed [OW-1:0] b2den_ff;
   logic                 use_in, sel_a;
   logic [TY-1:0]        b2tag_ff, b2tag_in;

   // Y divider.
   logic                 yv;
   logic signed [W-1:0]  my;
   logic [TY-1:0]        ytag;
   logic                 y_use;
   rel_type              y_rel;
   logic signed [W1-1:0] y_ka, y_kb;
   logic signed [W-1:0]  y_px, y_py;
   logic signed [W1-1:0] dpy;

   // X1 and X2.
   logic                 x1v_ff, x1v_in;
   logic signed [PW-1:0] t1_ff, t2_ff, t1_in, t2_in;
   logic signed [W1-1:0] x1ka_ff;
   logic [TX-1:0]        x1tag_ff;
   logic                 x2v_ff, x2v_in;
   logic signed [OW-1:0] numx_ff, numx_in;
   logic signed [W1-1:0] x2ka_ff;
   logic [TX-1:0]        x2tag_ff;

   // X divider and output register.
   logic                 xv;
   logic signed [W-1:0]  mx;
   logic [TX-1:0]        xtag;
   logic                 x_use;
   rel_type              x_rel;
   logic signed [W-1:0]  x_my;
   logic                 ov_ff, ov_in;
   logic                 oint_ff, oint_in;
   rel_type              orel_ff;
   logic signed [W-1:0]  omx_ff, omx_in, omy_ff, omy_in;

   assign en       = !ov_ff || out_ready;
   assign in_ready = en;

   assign c1_hi = c1[CW-1:W];
   assign c1_lo = $signed({1'b0, c1[W-1:0]});
   assign c2_hi = c2[CW-1:W];
   assign c2_lo = $signed({1'b0, c2[W-1:0]});

   assign b1v_in = in_valid;
   assign p1h_in = a1 * c2_hi;
   assign p1l_in = a1 * c2_lo;
   assign p2h_in = a2 * c1_hi;
   assign p2l_in = a2 * c1_lo;

   assign b2v_in = b1v_ff;
   assign num_hi = OW'(p1h_ff) - OW'(p2h_ff);
   assign num_lo = OW'(p1l_ff) - OW'(p2l_ff);
   assign num_in = (NW'(num_hi) <<< W) + NW'(num_lo);
   assign use_in = (b1rel_ff == REL_SINGLE) && (b1den_ff != '0) &&
                   ((b1a1_ff != '0) || (b1a2_ff != '0));
   assign sel_a  = (b1a1_ff != '0);
   assign b2tag_in = {use_in, b1rel_ff,
                      sel_a ? b1a1_ff : b1a2_ff,
                      sel_a ? b1b1_ff : b1b2_ff,
                      sel_a ? b1ax_ff : b1cx_ff,
                      sel_a ? b1ay_ff : b1cy_ff};

   segi_div #(
      .NW (NW),
      .DW (OW),
      .QW (W),
      .TW (TY)
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (b2v_ff),
      .num       (num_ff),
      .den       (b2den_ff),
      .in_tag    (b2tag_ff),
      .out_valid (yv),
      .quo       (my),
      .out_tag   (ytag)
   );

   assign {y_use, y_rel, y_ka, y_kb, y_px, y_py} = ytag;

   assign x1v_in = yv;
   assign dpy    = W1'(y_py) - W1'(my);
   assign t1_in  = y_ka * y_px;
   assign t2_in  = y_kb * dpy;

   assign x2v_in  = x1v_ff;
   assign numx_in = OW'(t1_ff) + OW'(t2_ff);

   segi_div #(
      .NW (OW),
      .DW (W1),
      .QW (W),
      .TW (TX)
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (x2v_ff),
      .num       (numx_ff),
      .den       (x2ka_ff),
      .in_tag    (x2tag_ff),
      .out_valid (xv),
      .quo       (mx),
      .out_tag   (xtag)
   );

   assign {x_use, x_rel, x_my} = xtag;

   assign ov_in   = xv;
   assign oint_in = (x_rel != REL_DISJOINT);
   assign omx_in  = x_use ? mx : '0;
   assign omy_in  = x_use ? x_my : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1v_ff <= 1'b0;
         b2v_ff <= 1'b0;
         x1v_ff <= 1'b0;
         x2v_ff <= 1'b0;
         ov_ff  <= 1'b0;
      end else if (en) begin
         b1v_ff <= b1v_in;
         b2v_ff <= b2v_in;
         x1v_ff <= x1v_in;
         x2v_ff <= x2v_in;
         ov_ff  <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1h_ff   <= p1h_in;
         p1l_ff   <= p1l_in;
         p2h_ff   <= p2h_in;
         p2l_ff   <= p2l_in;
         b1den_ff <= den;
         b1rel_ff <= rel;
         b1a1_ff  <= a1;
         b1b1_ff  <= b1;
         b1a2_ff  <= a2;
         b1b2_ff  <= b2;
         b1ax_ff  <= ax;
         b1ay_ff  <= ay;
         b1cx_ff  <= cx;
         b1cy_ff  <= cy;
         num_ff   <= num_in;
         b2den_ff <= b1den_ff;
         b2tag_ff <= b2tag_in;
         t1_ff    <= t1_in;
         t2_ff    <= t2_in;
         x1ka_ff  <= y_ka;
         x1tag_ff <= {y_use, y_rel, my};
         numx_ff  <= numx_in;
         x2ka_ff  <= x1ka_ff;
         x2tag_ff <= x1tag_ff;
         oint_ff  <= oint_in;
         orel_ff  <= x_rel;
         omx_ff   <= omx_in;
         omy_ff   <= omy_in;
      end
   end

   assign out_valid  = ov_ff;
   assign intersects = oint_ff;
   assign relation   = orel_ff;
   assign meet_x     = omx_ff;
   assign meet_y     = omy_ff;

endmodule

// File: rtl/core/segment_intersection_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection unit
// Classifies two segments AB and CD as disjoint, meeting in one point, or
// collinear and overlapping, and gives the meeting point.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Word contents (lowest bits first)
//   -------  ---  ---------------------------------------------------------
//   req_     in   a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y
//   rsp_     out  intersects, relation, meet_x, meet_y, zero pad to bytes
//
// One word is accepted per cycle and one result word leaves per cycle in
// steady state while rsp_tready stays high. The pipeline is two front-end
// stages, one queue slot, and a back end whose length is set by the two
// pipelined dividers, each one quotient bit per stage.
// Reset is synchronous and empties every pipeline stage and the queue.
// A stall on rsp_ holds the back end; the four-entry queue keeps the front
// end taking words until it fills, and then req_tready drops.
//
module segment_intersection_unit #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y; COORD_WIDTH bits each, signed
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [8*COORD_WIDTH-1:0]   req_tdata,
   // intersects (1), relation (2), meet_x (COORD_WIDTH), meet_y (COORD_WIDTH),
   // then zeros up to a whole byte
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [((2*COORD_WIDTH+3+7)/8)*8-1:0] rsp_tdata
);

   import segi_pkg::*;

   localparam int W        = COORD_WIDTH;
   localparam int RSP_BITS = 2 * W + 3;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;
   localparam int QDW      = 14 * W + 11;

   // Front end outputs.
   logic                  f_valid, q_full;
   rel_type               f_rel;
   logic signed [W-1:0]   f_ax, f_ay, f_cx, f_cy;
   logic signed [W:0]     f_a1, f_b1, f_a2, f_b2;
   logic signed [2*W:0]   f_c1, f_c2;
   logic signed [2*W+2:0] f_den;

   // Queue head.
   logic                  h_valid, h_pop;
   logic [QDW-1:0]        h_data;
   rel_type               h_rel;
   logic signed [W-1:0]   h_ax, h_ay, h_cx, h_cy;
   logic signed [W:0]     h_a1, h_b1, h_a2, h_b2;
   logic signed [2*W:0]   h_c1, h_c2;
   logic signed [2*W+2:0] h_den;

   // Result fields.
   logic                  r_int;
   rel_type               r_rel;
   logic signed [W-1:0]   r_mx, r_my;

   segi_front #(
      .W (W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_coords (req_tdata),
      .out_valid (f_valid),
      .out_ready (!q_full),
      .rel       (f_rel),
      .ax        (f_ax),
      .ay        (f_ay),
      .cx        (f_cx),
      .cy        (f_cy),
      .a1        (f_a1),
      .b1        (f_b1),
      .a2        (f_a2),
      .b2        (f_b2),
      .c1        (f_c1),
      .c2        (f_c2),
      .den       (f_den)
   );

   // The queue carries the classified pair with everything the back end
   // needs to form the meeting point.
   segi_queue #(
      .DW (QDW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (f_valid),
      .push_data  ({f_den, f_c2, f_c1, f_b2, f_a2, f_b1, f_a1,
                    f_cy, f_cx, f_ay, f_ax, f_rel}),
      .full       (q_full),
      .pop        (h_pop),
      .head_valid (h_valid),
      .head_data  (h_data)
   );

   assign {h_den, h_c2, h_c1, h_b2, h_a2, h_b1, h_a1,
           h_cy, h_cx, h_ay, h_ax, h_rel} = h_data;

   segi_back #(
      .W (W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (h_valid),
      .in_ready   (h_pop),
      .rel        (h_rel),
      .ax         (h_ax),
      .ay         (h_ay),
      .cx         (h_cx),
      .cy         (h_cy),
      .a1         (h_a1),
      .b1         (h_b1),
      .a2         (h_a2),
      .b2         (h_b2),
      .c1         (h_c1),
      .c2         (h_c2),
      .den        (h_den),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .intersects (r_int),
      .relation   (r_rel),
      .meet_x     (r_mx),
      .meet_y     (r_my)
   );

   // The field total is always odd, so there is at least one pad bit.
   assign rsp_tdata = {(RSP_W - RSP_BITS)'(0), r_my, r_mx, r_rel, r_int};

endmodule

// File: rtl/core/segi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection checker
// Port-level assertions on the result channel and req_tready, bound to the top level.
// ----------------------------------------------------------------------------
module segi_checker #(
   parameter int COORD_WIDTH = 16
) (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     req_tready,
   input logic                                     rsp_tvalid,
   input logic                                     rsp_tready,
   input logic [((2*COORD_WIDTH+3+7)/8)*8-1:0]     rsp_tdata
);

   import segi_pkg::*;

   localparam int W = COORD_WIDTH;

   logic                intersects;
   rel_type             relation;
   logic [W-1:0]        meet_x, meet_y;

   assign intersects = rsp_tdata[0];
   assign relation   = rsp_tdata[2:1];
   assign meet_x     = rsp_tdata[W+2:3];
   assign meet_y     = rsp_tdata[2*W+2:W+3];

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (intersects == (relation != REL_DISJOINT)) &&
                     (relation == REL_DISJOINT || relation == REL_SINGLE ||
                      relation == REL_OVERLAP))
      else $error("intersects flag disagrees with relation");

   a_point: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && relation != REL_SINGLE |-> meet_x == '0 && meet_y == '0)
      else $error("meeting point not zero without a single meeting point");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

endmodule

bind segment_intersection_unit segi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_segi_checker (.*);

// File: sim/segment_intersection_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection unit testbench
// Streams segment pairs into the unit under bursty, stalling traffic and
// checks every result word against a behavioral model of the classifier.
// ----------------------------------------------------------------------------
module segment_intersection_unit_test;
   import segi_pkg::*;

   localparam int CW = 16;
   localparam int RSP_W = ((2*CW+3+7)/8)*8;

   typedef struct {
      logic [8*CW-1:0] coords;
      bit              hold;   // wait for every pending result before offering
   } pair_type;

   typedef struct {
      logic          intersects;
      rel_type       relation;
      logic [CW-1:0] meet_x;
      logic [CW-1:0] meet_y;
   } meeting_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [8*CW-1:0]  req_tdata;    // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;    // intersects, relation, meet_x, meet_y, pad

   pair_type    pending_pairs[$];
   meeting_type expected_meetings[$];
   int          errors = 0;
   int          checked = 0;
   int          rel_count[3] = '{0, 0, 0};
   int          cycle_count = 0;

   segment_intersection_unit #(.COORD_WIDTH(CW)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Behavioral model of the classifier.
   // ------------------------------------------------------------------------
   function automatic int sign_of(longint v);
      return int'(v > 0) - int'(v < 0);
   endfunction

   function automatic longint turn(longint px, longint py, longint qx, longint qy,
                                   longint rx, longint ry);
      return (qx - px) * (ry - py) - (qy - py) * (rx - px);
   endfunction

   function automatic meeting_type predict_meeting(logic [8*CW-1:0] w);
      longint ax, ay, bx, by, cx, cy, dx, dy;
      longint a1, b1, c1, a2, b2, c2, den, num, q, mx, my;
      int s1, s2, s3, s4;
      bit ox, oy;
      meeting_type m;
      ax = $signed(w[0*CW +: CW]); ay = $signed(w[1*CW +: CW]);
      bx = $signed(w[2*CW +: CW]); by = $signed(w[3*CW +: CW]);
      cx = $signed(w[4*CW +: CW]); cy = $signed(w[5*CW +: CW]);
      dx = $signed(w[6*CW +: CW]); dy = $signed(w[7*CW +: CW]);
      s1 = sign_of(turn(cx, cy, dx, dy, ax, ay));
      s2 = sign_of(turn(cx, cy, dx, dy, bx, by));
      s3 = sign_of(turn(ax, ay, bx, by, cx, cy));
      s4 = sign_of(turn(ax, ay, bx, by, dx, dy));
      mx = 0;
      my = 0;
      m.relation = REL_DISJOINT;
      if (s1 == 0 && s2 == 0 && s3 == 0 && s4 == 0) begin
         // Collinear: bounding boxes decide, a shared endpoint counts.
         ox = ((ax > bx ? ax : bx) >= (cx < dx ? cx : dx)) &&
              ((cx > dx ? cx : dx) >= (ax < bx ? ax : bx));
         oy = ((ay > by ? ay : by) >= (cy < dy ? cy : dy)) &&
              ((cy > dy ? cy : dy) >= (ay < by ? ay : by));
         if (ox && oy) m.relation = REL_OVERLAP;
      end else if (s1 * s2 <= 0 && s3 * s4 <= 0) begin
         a1 = ay - by; b1 = bx - ax; c1 = -(a1 * ax + b1 * ay);
         a2 = cy - dy; b2 = dx - cx; c2 = -(a2 * cx + b2 * cy);
         den = a2 * b1 - a1 * b2;
         m.relation = REL_SINGLE;
         if (den != 0) begin
            num = a1 * c2 - a2 * c1;
            // Truncating quotient, magnitude clamped to 2**40.
            q = (num < 0 ? -num : num) / (den < 0 ? -den : den);
            if (q > 64'sd1 << 40) q = 64'sd1 << 40;
            my = ((num < 0) != (den < 0)) ? -q : q;
            if (a1 != 0) mx = (a1 * ax + b1 * (ay - my)) / a1;
            else if (a2 != 0) mx = (a2 * cx + b2 * (cy - my)) / a2;
            else my = 0;
         end
      end
      m.intersects = (m.relation != REL_DISJOINT);
      m.meet_x = mx[CW-1:0];
      m.meet_y = my[CW-1:0];
      return m;
   endfunction

   // ------------------------------------------------------------------------
   // Driver: bursts of random length separated by random gaps. The valid is
   // kept high until the word is taken, so one assignment per edge suffices.
   // ------------------------------------------------------------------------
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      bit taken;
      bit offer;
      taken = 1'b0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_meetings.insert(expected_meetings.size(),
                                     predict_meeting(req_tdata));
            void'(pending_pairs.pop_front());
            taken = 1'b1;
         end
         if (req_tvalid && !taken) begin
            req_tvalid <= 1'b1;
         end else begin
            offer = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_pairs.size() > 0 &&
                         !(pending_pairs[0].hold && expected_meetings.size() > 0)) begin
               offer = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(40, 1);
                  gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
               end
            end
            req_tvalid <= offer;
            if (offer) req_tdata <= pending_pairs[0].coords;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random stalls, plus one long hold-off that lets the unit's
   // queue fill so that req_tready has to drop.
   // ------------------------------------------------------------------------
   int stall_mode = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 500 == 0) stall_mode = $urandom_range(2, 0);
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (cycle_count >= 300 && cycle_count < 600) begin
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(3, 0) != 0);
            default: rsp_tready <= ($urandom_range(1, 0) != 0);
         endcase
      end
   end

   // Monitor: compare each result word with the oldest expectation.
   always @(posedge clock) begin
      meeting_type want;
      meeting_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.intersects = rsp_tdata[0];
         got.relation = rsp_tdata[2:1];
         got.meet_x = rsp_tdata[3 +: CW];
         got.meet_y = rsp_tdata[3+CW +: CW];
         if (expected_meetings.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = expected_meetings.pop_front();
            checked++;
            if (want.relation <= REL_OVERLAP) rel_count[want.relation]++;
            if (got.intersects !== want.intersects) begin
               $display("%0t: intersects expected %b actual %b",
                        $time, want.intersects, got.intersects);
               errors++;
            end
            if (got.relation !== want.relation) begin
               $display("%0t: relation expected %0d actual %0d",
                        $time, want.relation, got.relation);
               errors++;
            end
            if (got.meet_x !== want.meet_x) begin
               $display("%0t: meet_x expected %0d actual %0d", $time,
                        $signed(want.meet_x), $signed(got.meet_x));
               errors++;
            end
            if (got.meet_y !== want.meet_y) begin
               $display("%0t: meet_y expected %0d actual %0d", $time,
                        $signed(want.meet_y), $signed(got.meet_y));
               errors++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------------
   task automatic add_pair(int ax, int ay, int bx, int by,
                           int cx, int cy, int dx, int dy, bit hold = 0);
      pair_type p;
      p.coords = {dy[CW-1:0], dx[CW-1:0], cy[CW-1:0], cx[CW-1:0],
                  by[CW-1:0], bx[CW-1:0], ay[CW-1:0], ax[CW-1:0]};
      p.hold = hold;
      pending_pairs.insert(pending_pairs.size(), p);
   endtask

   function automatic int rnd_coord(int span);
      if (span == 0) return $signed($urandom_range(65535, 0)) - 32768;
      return $signed($urandom_range(2*span, 0)) - span;
   endfunction

   localparam int MX = 32767;
   localparam int MN = -32768;

   initial begin
      int span, ax, ay, bx, by, cx, cy, dx, dy, k, t;
      reset = 1'b1;

      // Directed pairs.
      add_pair(0, 0, 10, 10, 0, 10, 10, 0);          // proper crossing
      add_pair(0, 0, 10, 0, 10, 0, 10, 10);          // touching endpoints
      add_pair(0, 0, 10, 0, 5, 0, 5, 7);             // T junction
      add_pair(0, 0, 10, 0, 5, 0, 20, 0);            // collinear overlap
      add_pair(0, 0, 10, 0, 10, 0, 20, 0);           // collinear, one shared end
      add_pair(0, 0, 10, 0, 11, 0, 20, 0);           // collinear, apart
      add_pair(0, 0, 10, 0, 0, 1, 10, 1);            // parallel
      add_pair(0, 0, 10, 10, 20, 0, 30, -10);        // disjoint, not parallel
      add_pair(3, 3, 3, 3, 0, 0, 6, 6);              // point on a segment
      add_pair(3, 3, 3, 3, 3, 3, 3, 3);              // two equal points
      add_pair(3, 3, 3, 3, 5, 5, 5, 5);              // two different points
      add_pair(3, 4, 3, 4, 0, 0, 6, 6);              // point off a segment
      add_pair(MN, MN, MX, MX, MN, MX, MX, MN);      // full-range diagonals
      add_pair(MN, MN, MX, MN, MN, MX, MX, MX);      // extreme parallels
      add_pair(MN, MX, MX, MN, MN, MX, MX, MN);      // identical extreme segments
      add_pair(MX, MX, MN, MN, 0, MN, -1, MX);       // steep crossing
      add_pair(MN, 0, MX, 1, 0, MN, 1, MX);          // near-axis crossing
      add_pair(-1, -1, -1, -1, -1, -1, -1, -1);      // all ones
      add_pair(0, 0, 7, 3, 2, 5, 5, -4);             // non-integer meeting point
      add_pair(0, 0, -7, -3, -2, -5, -5, 4);         // negative rounding toward zero

      for (k = 0; k < 800; k++) begin
         t = $urandom_range(9, 0);
         span = ($urandom_range(1, 0) != 0) ? 0 : $urandom_range(64, 2);
         ax = rnd_coord(span); ay = rnd_coord(span);
         bx = rnd_coord(span); by = rnd_coord(span);
         cx = rnd_coord(span); cy = rnd_coord(span);
         dx = rnd_coord(span); dy = rnd_coord(span);
         if (t == 0) begin
            // Shared endpoint.
            cx = bx; cy = by;
         end else if (t == 1) begin
            // Collinear along a small step vector.
            span = $urandom_range(8, 1);
            dx = $signed($urandom_range(6, 0)) - 3;
            dy = $signed($urandom_range(6, 0)) - 3;
            ax = rnd_coord(200); ay = rnd_coord(200);
            bx = ax + dx * $urandom_range(span, 0);
            by = ay + dy * $urandom_range(span, 0);
            cx = ax + dx * ($signed($urandom_range(2*span, 0)) - span);
            cy = ay + dy * ($signed($urandom_range(2*span, 0)) - span);
            t = $signed($urandom_range(2*span, 0)) - span;
            dx = ax + dx * t; dy = ay + dy * t;
         end else if (t == 2) begin
            // Degenerate first segment.
            bx = ax; by = ay;
         end
         add_pair(ax, ay, bx, by, cx, cy, dx, dy, (k == 400));
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      wait (pending_pairs.size() == 0 && !req_tvalid);
      wait (expected_meetings.size() == 0);
      repeat (100) @(posedge clock);
      $display("Checked %0d results: %0d disjoint, %0d single point, %0d collinear overlap.",
               checked, rel_count[0], rel_count[1], rel_count[2]);
      $display("Traffic included bursts, receiver stalls, a long hold-off and a drain pause.");
      if (errors == 0 && expected_meetings.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Timeout with %0d results outstanding.", expected_meetings.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: files.f
rtl/core/segi_pkg.sv
rtl/core/segi_div.sv
rtl/core/segi_front.sv
rtl/core/segi_queue.sv
rtl/core/segi_back.sv
rtl/core/segment_intersection_unit.sv
rtl/core/segi_checker.sv
sim/segment_intersection_unit_test.sv
